/* src/assert_macros.svh */
// Assertion macros shared by the tile cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LBB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LBB_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define LBB_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBB_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* src/lbbtc_pkg.sv */
// Types, codes and defaults of the byte budget LRU tile cache.
`timescale 1ns / 1ps
package lbbtc_pkg;
  localparam int ENTRIES_DEF  = 16;
  localparam int OVERHEAD_DEF = 64;
  localparam logic [31:0] MAX_BYTES_RST = 32'd16777216;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_LOOKUP   = 2'd1;
  localparam logic [1:0] CMD_PURGE    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_MISS      = 2'd2;
  localparam logic [1:0] STAT_PURGED    = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] map;
    logic [31:0] scale;
    logic [4:0]  bits;
    logic [31:0] x;
    logic [31:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] image;
    logic [31:0] bytes;
  } entry_t;
endpackage

/* src/lbbtc_cell.sv */
// One recency position of the tile cache: entry storage and region match.
`timescale 1ns / 1ps
module lbbtc_cell import lbbtc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_op_e op_i,
  input  entry_t   prev_i,
  input  entry_t   req_i,
  output entry_t   entry_o,
  output logic     match_o
);
  logic   valid_q;
  entry_t data_q;
  logic signed [32:0] end_x, end_y, req_end_x, req_end_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (op_i)
        CELL_SHIFT: valid_q <= prev_i.valid;
        CELL_CLEAR: valid_q <= 1'b0;
        default:    valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == CELL_SHIFT) begin
      data_q <= prev_i;
    end
  end

  always_comb begin
    entry_o = data_q;
    entry_o.valid = valid_q;
  end

  assign end_x     = $signed({data_q.x[31], data_q.x}) + $signed({20'b0, data_q.w});
  assign end_y     = $signed({data_q.y[31], data_q.y}) + $signed({20'b0, data_q.h});
  assign req_end_x = $signed({req_i.x[31], req_i.x}) + $signed({20'b0, req_i.w});
  assign req_end_y = $signed({req_i.y[31], req_i.y}) + $signed({20'b0, req_i.h});

  assign match_o = valid_q && (data_q.map == req_i.map)
                && ($signed(data_q.x) <= $signed(req_i.x))
                && ($signed(data_q.y) <= $signed(req_i.y))
                && (end_x >= req_end_x) && (end_y >= req_end_y)
                && (data_q.scale == req_i.scale)
                && ((req_i.bits == 5'd0) || (data_q.bits == req_i.bits));
endmodule

/* src/lru_byte_budget_tile_cache.sv */
// Top level of the byte budget LRU tile cache: command sequencer over a chain of cells.
//  channel   direction  handshake                      word
//  command   in         start high, busy low           command and tile fields
//  result    out        result_strobe_o, one cycle     status, hit data, bytes_in_use
//  config    in         cfg_valid_i and cfg_ready_o    max_bytes
// Purge and the unused command end in idle; a rejected add goes multiply, check, idle.
// An accepted add: multiply, check, one eviction a cycle from the LRU end, then insert.
// A lookup walks one cell a cycle from MRU.
// Reset empties the chain at once and loads the budget with 16777216.
// Results cannot be stalled; busy holds off commands until the result strobe.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_byte_budget_tile_cache import lbbtc_pkg::*; #(
  parameter int ENTRIES        = ENTRIES_DEF,
  parameter int ENTRY_OVERHEAD = OVERHEAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] map_id_i,
  input  logic [31:0] tile_x_i,
  input  logic [31:0] tile_y_i,
  input  logic [12:0] tile_width_i,
  input  logic [12:0] tile_height_i,
  input  logic [4:0]  sample_bits_i,
  input  logic [31:0] scale_code_i,
  input  logic [15:0] image_handle_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        result_strobe_o,
  output logic [1:0]  status_o,
  output logic [15:0] hit_handle_o,
  output logic [31:0] hit_x_o,
  output logic [31:0] hit_y_o,
  output logic [12:0] hit_width_o,
  output logic [12:0] hit_height_o,
  output logic [4:0]  hit_sample_bits_o,
  output logic [31:0] bytes_in_use_o
);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [31:0] OVH = 32'(ENTRY_OVERHEAD);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_LKUP  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [31:0]        max_q;
  logic [31:0]        used_q, used_d;
  logic [CW-1:0]      count_q, count_d;
  logic [ENTRIES-1:0] tok_q, tok_d;
  entry_t             req_q;
  logic [25:0]        prod_q;
  logic [31:0]        cost_q;
  logic [30:0]        prod2;

  logic        strobe_q, strobe_d;
  logic [1:0]  status_q, status_d;
  entry_t      hitent_q, hitent_d;

  entry_t             ent [ENTRIES];
  entry_t             prev [ENTRIES];
  cell_op_e           op [ENTRIES];
  logic [ENTRIES-1:0] match, vld, last, hit, mask;
  logic [31:0]        last_bytes;
  entry_t             hit_ent, head;
  logic               accept, evict_cond, tok_vld;

  assign accept      = start && !busy;
  assign busy        = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign prev[g] = head;
      end else begin : g_link
        assign prev[g] = ent[g-1];
      end
      lbbtc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .op_i    (op[g]),
        .prev_i  (prev[g]),
        .req_i   (req_q),
        .entry_o (ent[g]),
        .match_o (match[g])
      );
      assign vld[g] = ent[g].valid;
      if (g == ENTRIES - 1) begin : g_tail
        assign last[g] = ent[g].valid;
      end else begin : g_mid
        assign last[g] = ent[g].valid && !ent[g+1].valid;
      end
    end
  endgenerate

  assign hit  = (state_q == ST_LKUP) ? (tok_q & match) : '0;
  assign mask = tok_q | (tok_q - ENTRIES'(1));
  assign tok_vld = |(tok_q & vld);

  always_comb begin
    last_bytes = '0;
    hit_ent    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (last[i]) last_bytes = last_bytes | ent[i].bytes;
      if (hit[i])  hit_ent    = hit_ent | ent[i];
    end
  end

  always_comb begin
    head = hit_ent;
    if (state_q == ST_EVICT) begin
      head = req_q;
      head.valid = 1'b1;
      head.bytes = cost_q;
    end
  end

  assign evict_cond = (count_q != '0)
                   && ((count_q == CW'(ENTRIES))
                       || (({1'b0, used_q} + {1'b0, cost_q}) > {1'b0, max_q}));

  assign prod2 = 31'(prod_q) * 31'(req_q.bits);

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    count_d  = count_q;
    tok_d    = tok_q;
    strobe_d = 1'b0;
    status_d = status_q;
    hitent_d = hitent_q;
    for (int i = 0; i < ENTRIES; i++) op[i] = CELL_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hitent_d = '0;
          case (command_i)
            CMD_ADD:    state_d = ST_MUL;
            CMD_LOOKUP: begin
              state_d = ST_LKUP;
              tok_d   = ENTRIES'(1);
            end
            CMD_PURGE: begin
              for (int i = 0; i < ENTRIES; i++) op[i] = CELL_CLEAR;
              used_d   = '0;
              count_d  = '0;
              strobe_d = 1'b1;
              status_d = STAT_PURGED;
            end
            default: begin
              strobe_d = 1'b1;
              status_d = STAT_MISS;
            end
          endcase
        end
      end
      ST_MUL: state_d = ST_CHK;
      ST_CHK: begin
        if (cost_q > max_q) begin
          state_d  = ST_IDLE;
          strobe_d = 1'b1;
          status_d = STAT_TOO_LARGE;
        end else begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (evict_cond) begin
          for (int i = 0; i < ENTRIES; i++) if (last[i]) op[i] = CELL_CLEAR;
          used_d  = used_q - last_bytes;
          count_d = count_q - CW'(1);
        end else begin
          for (int i = 0; i < ENTRIES; i++) op[i] = CELL_SHIFT;
          used_d   = used_q + cost_q;
          count_d  = count_q + CW'(1);
          state_d  = ST_IDLE;
          strobe_d = 1'b1;
          status_d = STAT_OK;
        end
      end
      ST_LKUP: begin
        if (|hit) begin
          for (int i = 0; i < ENTRIES; i++) if (mask[i]) op[i] = CELL_SHIFT;
          hitent_d = hit_ent;
          state_d  = ST_IDLE;
          strobe_d = 1'b1;
          status_d = STAT_OK;
        end else if (!tok_vld || tok_q[ENTRIES-1]) begin
          state_d  = ST_IDLE;
          strobe_d = 1'b1;
          status_d = STAT_MISS;
        end else begin
          tok_d = tok_q << 1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      max_q    <= MAX_BYTES_RST;
      used_q   <= '0;
      count_q  <= '0;
      tok_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      count_q  <= count_d;
      tok_q    <= tok_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hitent_q <= hitent_d;
    if (accept) begin
      req_q.valid <= 1'b0;
      req_q.map   <= map_id_i;
      req_q.scale <= scale_code_i;
      req_q.bits  <= sample_bits_i;
      req_q.x     <= tile_x_i;
      req_q.y     <= tile_y_i;
      req_q.w     <= tile_width_i;
      req_q.h     <= tile_height_i;
      req_q.image <= image_handle_i;
      req_q.bytes <= '0;
      prod_q      <= tile_width_i * tile_height_i;
    end
    if (state_q == ST_MUL) begin
      cost_q <= 32'(prod2 >> 3) + OVH;
    end
  end

  assign result_strobe_o   = strobe_q;
  assign status_o          = status_q;
  assign hit_handle_o      = hitent_q.image;
  assign hit_x_o           = hitent_q.x;
  assign hit_y_o           = hitent_q.y;
  assign hit_width_o       = hitent_q.w;
  assign hit_height_o      = hitent_q.h;
  assign hit_sample_bits_o = hitent_q.bits;
  assign bytes_in_use_o    = used_q;

  `LBB_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(ENTRIES), "entry count overflow")
  `LBB_ASSERT(a_valid_prefix, clk_i, rst_ni, (vld & (vld + ENTRIES'(1))) == '0, "valid hole")
  `LBB_ASSERT_IMPL(a_token_onehot, clk_i, rst_ni, state_q == ST_LKUP, $onehot(tok_q), "lookup token not one-hot")
  `LBB_ASSERT_IMPL(a_strobe_cause, clk_i, rst_ni, result_strobe_o, $past(busy) || $past(start), "result without command")
endmodule
